### rtl/dspe_pkg.sv
`default_nettype none
package dspe_pkg;

  localparam int NUM_VERTICES = 16;
  localparam int WEIGHT_BITS  = 16;
  localparam int DIST_BITS    = 24;
  localparam int VIDX_BITS    = $clog2(NUM_VERTICES);
  localparam int CNT_BITS     = VIDX_BITS + 1;
  localparam int EDGE_DEPTH   = NUM_VERTICES * NUM_VERTICES;

  localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};

  // command codes
  localparam logic [2:0] FN_ADD_VERTEX = 3'd0;
  localparam logic [2:0] FN_ADD_EDGE   = 3'd1;
  localparam logic [2:0] FN_DEL_EDGE   = 3'd2;
  localparam logic [2:0] FN_DEL_VERTEX = 3'd3;
  localparam logic [2:0] FN_RUN        = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_FAIL       = 2'd1;
  localparam logic [1:0] STAT_SRC_ABSENT = 2'd2;
  localparam logic [1:0] STAT_PATH       = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  node_a;
    logic [3:0]  node_b;
    logic [15:0] weight;
    logic        create_missing;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  vertex;
    logic [23:0] distance;
    logic [3:0]  predecessor;
    logic        last;
  } result_t;

  // one entry of the distance memory
  typedef struct packed {
    logic [DIST_BITS-1:0] dist_val;
    logic [VIDX_BITS-1:0] pred;
  } dent_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE2,
    S_INIT,
    S_SCAN,
    S_SDEC,
    S_RELAX,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

### rtl/dspe_ram.sv
`default_nettype none
module dspe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/dijkstra_shortest_path_engine.sv
`default_nettype none
// Graph edit commands (add/remove vertex or edge) are done in idle; a successful add edge
// holds busy in S_EDGE2 for the mirrored weight write. Their single result strobes in
// the cycle after the transfer. In a run, each settled vertex costs one scan pass and
// one relax pass over the distance memory, one entry per cycle; a final pass sends out
// path entries when any were reached. Results cannot be stalled. Synchronous active-high
// reset empties the graph and returns to idle.
module dijkstra_shortest_path_engine (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire dspe_pkg::cmd_t  cmd,
  output logic                 busy,
  output dspe_pkg::result_t    result,
  output logic                 result_valid
);

  localparam int NV = dspe_pkg::NUM_VERTICES;
  localparam int VB = dspe_pkg::VIDX_BITS;
  localparam int CB = dspe_pkg::CNT_BITS;
  localparam int DB = dspe_pkg::DIST_BITS;
  localparam int WB = dspe_pkg::WEIGHT_BITS;
  localparam int EB = $clog2(dspe_pkg::EDGE_DEPTH);

  dspe_pkg::state_t state, state_next;

  // graph topology lives in flops so whole rows/columns can be cleared together
  logic [NV-1:0] present, present_next;
  logic [NV-1:0] adj [NV];
  logic [NV-1:0] adj_next [NV];

  // per-run bookkeeping
  logic [NV-1:0] done_v, done_v_next;
  logic [NV-1:0] pvalid, pvalid_next;
  logic [CB-1:0] cnt, cnt_next;
  logic [VB-1:0] src, src_next;
  logic [VB-1:0] u, u_next;
  logic [DB-1:0] best, best_next;
  logic          found, found_next;

  // held operands for the mirrored weight write
  logic [VB-1:0] ea, ea_next, eb, eb_next;
  logic [WB-1:0] ew, ew_next;

  dspe_pkg::result_t res_next;
  logic              res_valid_next;

  // memories
  logic          w_we;
  logic [EB-1:0] w_waddr, w_raddr;
  logic [WB-1:0] w_wdata, w_rdata;
  logic          d_we;
  logic [VB-1:0] d_waddr, d_raddr;
  dspe_pkg::dent_t d_wdata, d_rdata;

  dspe_ram #(.WIDTH(WB), .DEPTH(dspe_pkg::EDGE_DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  dspe_ram #(.WIDTH($bits(dspe_pkg::dent_t)), .DEPTH(NV)) u_dist_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  // decoded command
  logic          accept;
  logic [VB-1:0] a, b;
  logic          a_in, b_in, pa, pb, joined, pa2, pb2, insert_ok;
  logic          run_ok;

  // scan pipeline: index being consumed this cycle (read issued last cycle)
  logic [VB-1:0] cidx;
  logic          consume, last_cnt;
  logic [NV-1:0] emit_mask;
  logic [DB:0]   sum;
  logic [DB-1:0] cand;

  assign busy    = (state != dspe_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign a       = cmd.node_a[VB-1:0];
  assign b       = cmd.node_b[VB-1:0];
  assign a_in    = (32'(cmd.node_a) < NV);
  assign b_in    = (32'(cmd.node_b) < NV);
  assign pa      = a_in && present[a];
  assign pb      = b_in && present[b];
  assign joined  = pa && pb && adj[a][b];
  // absent endpoints may be created first
  assign pa2     = pa || (cmd.create_missing && a_in);
  assign pb2     = pb || (cmd.create_missing && b_in);
  assign insert_ok = !joined && pa2 && pb2 && (a != b);
  assign run_ok  = pa;

  assign cidx     = VB'(cnt - CB'(1));
  assign consume  = (cnt != '0);
  assign last_cnt = (cnt == CB'(NV));
  assign emit_mask = present & pvalid & ~(NV'(1) << src);

  // relaxation candidate, saturating one below infinity
  assign sum  = {1'b0, best} + (DB+1)'(w_rdata);
  assign cand = (sum >= {1'b0, dspe_pkg::DIST_INF}) ? (dspe_pkg::DIST_INF - DB'(1))
                                                    : sum[DB-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dspe_pkg::S_IDLE: begin
        if (accept && cmd.func == dspe_pkg::FN_ADD_EDGE && insert_ok) begin
          state_next = dspe_pkg::S_EDGE2;
        end else if (accept && cmd.func == dspe_pkg::FN_RUN && run_ok) begin
          state_next = dspe_pkg::S_INIT;
        end
      end
      dspe_pkg::S_EDGE2: state_next = dspe_pkg::S_IDLE;
      dspe_pkg::S_INIT: begin
        if (cnt == CB'(NV - 1)) state_next = dspe_pkg::S_SCAN;
      end
      dspe_pkg::S_SCAN: begin
        if (last_cnt) state_next = dspe_pkg::S_SDEC;
      end
      dspe_pkg::S_SDEC: begin
        if (found) begin
          state_next = dspe_pkg::S_RELAX;
        end else if (emit_mask == '0) begin
          state_next = dspe_pkg::S_IDLE;
        end else begin
          state_next = dspe_pkg::S_OUT;
        end
      end
      dspe_pkg::S_RELAX: begin
        if (last_cnt) state_next = dspe_pkg::S_SCAN;
      end
      dspe_pkg::S_OUT: begin
        if (last_cnt) state_next = dspe_pkg::S_IDLE;
      end
      default: state_next = dspe_pkg::S_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    present_next   = present;
    adj_next       = adj;
    done_v_next    = done_v;
    pvalid_next    = pvalid;
    cnt_next       = cnt;
    src_next       = src;
    u_next         = u;
    best_next      = best;
    found_next     = found;
    ea_next        = ea;
    eb_next        = eb;
    ew_next        = ew;
    res_next       = '0;
    res_valid_next = 1'b0;
    w_we           = 1'b0;
    w_waddr        = {a, b};
    w_wdata        = cmd.weight[WB-1:0];
    w_raddr        = {u, cnt[VB-1:0]};
    d_we           = 1'b0;
    d_waddr        = cnt[VB-1:0];
    d_wdata        = '0;
    d_raddr        = cnt[VB-1:0];

    case (state)
      dspe_pkg::S_IDLE: begin
        if (accept) begin
          res_valid_next = 1'b1;
          res_next.last  = 1'b1;
          res_next.status = dspe_pkg::STAT_FAIL;
          case (cmd.func)
            dspe_pkg::FN_ADD_VERTEX: begin
              if (a_in) begin
                present_next[a] = 1'b1;
                res_next.status = dspe_pkg::STAT_OK;
              end
            end
            dspe_pkg::FN_ADD_EDGE: begin
              if (!joined) begin
                if (cmd.create_missing && a_in) present_next[a] = 1'b1;
                if (cmd.create_missing && b_in) present_next[b] = 1'b1;
              end
              if (insert_ok) begin
                adj_next[a][b]  = 1'b1;
                adj_next[b][a]  = 1'b1;
                w_we            = 1'b1;
                ea_next         = a;
                eb_next         = b;
                ew_next         = cmd.weight[WB-1:0];
                res_next.status = dspe_pkg::STAT_OK;
              end
            end
            dspe_pkg::FN_DEL_EDGE: begin
              if (pa && pb && a != b && adj[a][b]) begin
                adj_next[a][b]  = 1'b0;
                adj_next[b][a]  = 1'b0;
                res_next.status = dspe_pkg::STAT_OK;
              end
            end
            dspe_pkg::FN_DEL_VERTEX: begin
              if (pa) begin
                for (int r = 0; r < NV; r++) begin
                  adj_next[r][a] = 1'b0;
                end
                adj_next[a]     = '0;
                present_next[a] = 1'b0;
                res_next.status = dspe_pkg::STAT_OK;
              end
            end
            dspe_pkg::FN_RUN: begin
              if (run_ok) begin
                res_valid_next = 1'b0;
                done_v_next    = '0;
                pvalid_next    = '0;
                src_next       = a;
                cnt_next       = '0;
              end else begin
                res_next.status = dspe_pkg::STAT_SRC_ABSENT;
              end
            end
            default: ;
          endcase
        end
      end

      dspe_pkg::S_EDGE2: begin
        // mirrored weight entry
        w_we    = 1'b1;
        w_waddr = {eb, ea};
        w_wdata = ew;
      end

      dspe_pkg::S_INIT: begin
        d_we             = 1'b1;
        d_wdata.dist_val = (cnt[VB-1:0] == src) ? '0 : dspe_pkg::DIST_INF;
        d_wdata.pred     = '0;
        cnt_next         = cnt + CB'(1);
        if (cnt == CB'(NV - 1)) begin
          cnt_next   = '0;
          best_next  = dspe_pkg::DIST_INF;
          found_next = 1'b0;
        end
      end

      dspe_pkg::S_SCAN: begin
        // lowest index wins ties: strict compare in ascending order
        if (consume && present[cidx] && !done_v[cidx] && d_rdata.dist_val < best) begin
          best_next  = d_rdata.dist_val;
          u_next     = cidx;
          found_next = 1'b1;
        end
        cnt_next = last_cnt ? '0 : cnt + CB'(1);
      end

      dspe_pkg::S_SDEC: begin
        cnt_next = '0;
        if (found) begin
          done_v_next[u] = 1'b1;
        end else if (emit_mask == '0) begin
          res_valid_next  = 1'b1;
          res_next.status = dspe_pkg::STAT_OK;
          res_next.last   = 1'b1;
        end
      end

      dspe_pkg::S_RELAX: begin
        // read of index k overlaps write-back of k-1: never the same entry
        if (consume && adj[u][cidx] && present[cidx] && !done_v[cidx] &&
            cand < d_rdata.dist_val) begin
          d_we             = 1'b1;
          d_waddr          = cidx;
          d_wdata.dist_val = cand;
          d_wdata.pred     = u;
          pvalid_next[cidx] = 1'b1;
        end
        cnt_next = cnt + CB'(1);
        if (last_cnt) begin
          cnt_next   = '0;
          best_next  = dspe_pkg::DIST_INF;
          found_next = 1'b0;
        end
      end

      dspe_pkg::S_OUT: begin
        if (consume && emit_mask[cidx]) begin
          res_valid_next       = 1'b1;
          res_next.status      = dspe_pkg::STAT_PATH;
          res_next.vertex      = 4'(cidx);
          res_next.distance    = 24'(d_rdata.dist_val);
          res_next.predecessor = 4'(d_rdata.pred);
          res_next.last        = ((emit_mask >> cidx) >> 1) == '0;
        end
        cnt_next = last_cnt ? '0 : cnt + CB'(1);
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dspe_pkg::S_IDLE;
      present      <= '0;
      done_v       <= '0;
      pvalid       <= '0;
      cnt          <= '0;
      found        <= 1'b0;
      result_valid <= 1'b0;
      for (int r = 0; r < NV; r++) begin
        adj[r] <= '0;
      end
    end else begin
      state        <= state_next;
      present      <= present_next;
      done_v       <= done_v_next;
      pvalid       <= pvalid_next;
      cnt          <= cnt_next;
      found        <= found_next;
      result_valid <= res_valid_next;
      adj          <= adj_next;
    end
    src    <= src_next;
    u      <= u_next;
    best   <= best_next;
    ea     <= ea_next;
    eb     <= eb_next;
    ew     <= ew_next;
    result <= res_next;
  end

endmodule
`default_nettype wire

### rtl/dspe_checker.sv
`default_nettype none
module dspe_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire dspe_pkg::cmd_t    cmd,
  input wire logic              busy,
  input wire dspe_pkg::result_t result,
  input wire logic              result_valid
);

  // every transfer either answers next cycle or keeps the engine busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> result_valid || busy)
    else $error("transfer neither answered nor in progress");

  // unused command codes answer failed at once
  a_unused_fail: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.func > dspe_pkg::FN_RUN |=>
      result_valid && result.status == dspe_pkg::STAT_FAIL)
    else $error("unused command code not answered as failed");

  // only path entries may be non-final
  a_single_final: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != dspe_pkg::STAT_PATH |-> result.last)
    else $error("non-path result without last");

  // reached vertices never carry the infinity code
  a_no_inf: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == dspe_pkg::STAT_PATH |-> ~&result.distance)
    else $error("path entry at infinity");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !result_valid)
    else $error("not idle after reset");

endmodule

bind dijkstra_shortest_path_engine dspe_checker u_dspe_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .cmd          (cmd),
  .busy         (busy),
  .result       (result),
  .result_valid (result_valid)
);
`default_nettype wire
